// ----- rtl/htw_pkg.sv -----
// Shared types and constants for the hierarchical timer wheel.
`default_nettype none
package htw_pkg;
  localparam int unsigned NUM_TIMERS  = 64;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned TIME_W      = 27;
  localparam logic [TIME_W-1:0] TIMEOUT_CEIL = TIME_W'(1000*3600*24-1);

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ARM  = 1'b1;
  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_FIRE = 1'b1;
  localparam logic STS_OK  = 1'b0;
  localparam logic STS_REJ = 1'b1;

  // Broadcast control from the scan controller to every cell.
  typedef struct packed {
    logic              tick;
    logic              arm;
    logic              periodic;
    logic [TIME_W-1:0] timeout;
    logic              adv;
    logic              start;
  } htw_ctl_t;
endpackage
`default_nettype wire

// ----- rtl/htw_cell.sv -----
// One timer entry: countdown, period, fire flag and a scan token stage.
`default_nettype none
module htw_cell (
  input  wire                       clk,
  input  wire                       rst_n,
  input  htw_pkg::htw_ctl_t         ctl,
  input  wire                       sel,
  input  wire                       tok_in,
  output logic                      tok_out,
  output logic                      hit
);
  import htw_pkg::*;

  logic              act_r, per_r, pend_r, tok_r;
  logic [TIME_W-1:0] rem_r, period_r;

  // Control flags and token
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      per_r  <= 1'b0;
      pend_r <= 1'b0;
      tok_r  <= 1'b0;
    end else begin
      if (ctl.start || ctl.adv) begin
        tok_r <= tok_in;
      end
      if (ctl.arm && sel) begin
        act_r <= 1'b1;
        per_r <= ctl.periodic;
      end else if (ctl.tick && act_r && rem_r == TIME_W'(1)) begin
        pend_r <= 1'b1;
        act_r  <= per_r;
      end else if (tok_r && ctl.adv) begin
        pend_r <= 1'b0;
      end
    end
  end

  // Countdown and period payload
  always_ff @(posedge clk) begin
    if (ctl.arm && sel) begin
      rem_r    <= ctl.timeout;
      period_r <= ctl.timeout;
    end else if (ctl.tick && act_r) begin
      if (rem_r == TIME_W'(1)) begin
        rem_r <= period_r;
      end else begin
        rem_r <= rem_r - TIME_W'(1);
      end
    end
  end

  assign tok_out = tok_r;
  assign hit     = tok_r & pend_r;
endmodule
`default_nettype wire

// ----- rtl/hierarchical_timer_wheel.sv -----
// Top level: row of 64 timer cells with a token scan and result register.
// Arm: one ack beat, ready in the cycle after acceptance.
// Tick: every entry counts down at once, then a token walks the 64 cells,
// one cell per cycle unless output back-pressure holds it.
// Fired entries come out in ascending slot order; the last one carries last.
// Synchronous active-low reset marks all timers inactive.
`default_nettype none
module hierarchical_timer_wheel (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire                           in_op,
  input  wire [htw_pkg::SLOT_W-1:0]     in_timer_slot,
  input  wire [htw_pkg::TIME_W-1:0]     in_timeout_ms,
  input  wire                           in_periodic,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic                          out_kind,
  output logic [htw_pkg::SLOT_W-1:0]    out_fired_slot,
  output logic                          out_status,
  output logic                          out_last
);
  import htw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [SLOT_W-1:0]   idx_r;
  logic                buf_v_r;
  logic [SLOT_W-1:0]   buf_slot_r;
  logic                out_valid_r;
  logic                out_free, acc, bad, hit_any, adv;
  logic [NUM_TIMERS-1:0] hits, toks;
  logic [NUM_TIMERS:0]   chain;
  htw_ctl_t            ctl;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !(state_r == ST_IDLE && out_free);
  assign acc      = in_valid && !in_stall;
  assign bad      = (in_timeout_ms == '0) || (in_timeout_ms > TIMEOUT_CEIL);
  assign hit_any  = |hits;
  assign adv      = (state_r == ST_SCAN) && (out_free || !(hit_any && buf_v_r));

  always_comb begin
    ctl.tick     = acc && in_op == OP_TICK;
    ctl.arm      = acc && in_op == OP_ARM && !bad;
    ctl.periodic = in_periodic;
    ctl.timeout  = in_timeout_ms;
    ctl.adv      = adv;
    ctl.start    = ctl.tick;
  end

  // Cell row with the scan token handed down the chain
  assign chain[0] = ctl.start;
  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    htw_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .sel    (in_timer_slot == SLOT_W'(g)),
      .tok_in (chain[g]),
      .tok_out(chain[g+1]),
      .hit    (hits[g])
    );
    assign toks[g] = chain[g+1];
  end

  // Scan sequencing
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (ctl.tick) state_nxt = ST_SCAN;
      ST_SCAN:  if (adv && idx_r == SLOT_W'(NUM_TIMERS-1)) state_nxt = ST_FLUSH;
      ST_FLUSH: if (!buf_v_r || out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      buf_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_free) out_valid_r <= 1'b0;
      if (ctl.tick) idx_r <= '0;
      else if (adv) idx_r <= idx_r + SLOT_W'(1);
      if (acc && in_op == OP_ARM) begin
        out_valid_r <= 1'b1;
      end else if (adv && hit_any) begin
        buf_v_r <= 1'b1;
        if (buf_v_r) out_valid_r <= 1'b1;
      end else if (state_r == ST_FLUSH && buf_v_r && out_free) begin
        buf_v_r     <= 1'b0;
        out_valid_r <= 1'b1;
      end
    end
  end

  // Result payload and held fired slot
  always_ff @(posedge clk) begin
    if (acc && in_op == OP_ARM) begin
      out_kind       <= KIND_ACK;
      out_fired_slot <= in_timer_slot;
      out_status     <= bad ? STS_REJ : STS_OK;
      out_last       <= 1'b1;
    end else if (adv && hit_any) begin
      buf_slot_r <= idx_r;
      if (buf_v_r) begin
        out_kind       <= KIND_FIRE;
        out_fired_slot <= buf_slot_r;
        out_status     <= STS_OK;
        out_last       <= 1'b0;
      end
    end else if (state_r == ST_FLUSH && buf_v_r && out_free) begin
      out_kind       <= KIND_FIRE;
      out_fired_slot <= buf_slot_r;
      out_status     <= STS_OK;
      out_last       <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_tok_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(toks))
    else $error("more than one scan token");
  a_no_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> in_stall) else $error("input taken during scan");
  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind == KIND_ACK |-> out_last) else $error("ack without last");
  a_idle_nobuf: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !buf_v_r) else $error("held fire left in idle");
`endif
endmodule
`default_nettype wire

// ----- tb/hierarchical_timer_wheel_check.sv -----
// Checker for the timer wheel: watches both channels, predicts beats, compares.
`timescale 1ns / 100ps
`default_nettype none
module hierarchical_timer_wheel_check (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  input  wire                          in_stall,
  input  wire                          in_op,
  input  wire [htw_pkg::SLOT_W-1:0]    in_timer_slot,
  input  wire [htw_pkg::TIME_W-1:0]    in_timeout_ms,
  input  wire                          in_periodic,
  input  wire                          out_valid,
  input  wire                          out_stall,
  input  wire                          out_kind,
  input  wire [htw_pkg::SLOT_W-1:0]    out_fired_slot,
  input  wire                          out_status,
  input  wire                          out_last,
  output int                           fail_count,
  output int                           pending
);
  import htw_pkg::*;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic              status;
    logic              last;
  } beat_t;

  // Timer state as the block should hold it
  logic [63:0]       now_ms;
  logic [63:0]       due_ms [NUM_TIMERS];
  logic [TIME_W-1:0] period_ms [NUM_TIMERS];
  logic              armed [NUM_TIMERS];
  logic              rearm [NUM_TIMERS];

  beat_t due_beats[$];

  assign pending = due_beats.size();

  // Work out the beats that one accepted input causes
  task automatic predict_item(input logic op, input logic [SLOT_W-1:0] slot,
                              input logic [TIME_W-1:0] tmo, input logic per);
    beat_t b;
    int    first_fire;
    int    last_fire;
    first_fire = due_beats.size();
    last_fire  = -1;
    if (op == OP_ARM) begin
      b.kind = KIND_ACK;
      b.slot = slot;
      b.last = 1'b1;
      if (tmo == '0 || tmo > TIMEOUT_CEIL) begin
        b.status = STS_REJ;
      end else begin
        b.status = STS_OK;
        due_ms[slot]    = now_ms + 64'(tmo);
        period_ms[slot] = tmo;
        armed[slot]     = 1'b1;
        rearm[slot]     = per;
      end
      due_beats.insert(due_beats.size(), b);
    end else begin
      now_ms = now_ms + 64'd1;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (armed[i] && due_ms[i] == now_ms) begin
          b.kind   = KIND_FIRE;
          b.slot   = SLOT_W'(i);
          b.status = STS_OK;
          b.last   = 1'b0;
          due_beats.insert(due_beats.size(), b);
          last_fire = due_beats.size() - 1;
          if (rearm[i]) due_ms[i] = now_ms + 64'(period_ms[i]);
          else armed[i] = 1'b0;
        end
      end
      if (last_fire >= first_fire) due_beats[last_fire].last = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    beat_t want;
    if (!rst_n) begin
      now_ms = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        armed[i] = 1'b0;
        rearm[i] = 1'b0;
      end
      due_beats.delete();
      fail_count <= 0;
    end else begin
      // result beat against oldest expectation
      if (out_valid && !out_stall) begin
        if (due_beats.size() == 0) begin
          $display("%0t: unexpected beat kind=%0d slot=%0d status=%0d last=%0d",
                   $time, out_kind, out_fired_slot, out_status, out_last);
          fail_count <= fail_count + 1;
        end else begin
          want = due_beats.pop_front();
          if (want.kind !== out_kind || want.slot !== out_fired_slot ||
              want.status !== out_status || want.last !== out_last) begin
            $display("%0t: expected kind=%0d slot=%0d status=%0d last=%0d, got kind=%0d slot=%0d status=%0d last=%0d",
                     $time, want.kind, want.slot, want.status, want.last,
                     out_kind, out_fired_slot, out_status, out_last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        predict_item(in_op, in_timer_slot, in_timeout_ms, in_periodic);
    end
  end

endmodule
`default_nettype wire

// ----- tb/hierarchical_timer_wheel_test.sv -----
// Testbench top for the timer wheel: stimulus, back-pressure and verdict.
`timescale 1ns / 100ps
`default_nettype none
module hierarchical_timer_wheel_test;
  import htw_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_op;
  logic [SLOT_W-1:0] in_timer_slot;
  logic [TIME_W-1:0] in_timeout_ms;
  logic              in_periodic;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_kind;
  logic [SLOT_W-1:0] out_fired_slot;
  logic              out_status;
  logic              out_last;
  int                fail_count;
  int                pending;
  int                cycle = 0;
  logic              calm;

  hierarchical_timer_wheel DUT (.*);

  hierarchical_timer_wheel_check checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // cycle count, watchdog, and a stretch with no idling on either side
  assign calm = (cycle >= 3000 && cycle < 9000);

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk)
    out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 14);

  // present one beat and hold it until taken, then maybe go idle
  task automatic drive_item(input logic op, input logic [SLOT_W-1:0] slot,
                            input logic [TIME_W-1:0] tmo, input logic per);
    in_valid      <= 1'b1;
    in_op         <= op;
    in_timer_slot <= slot;
    in_timeout_ms <= tmo;
    in_periodic   <= per;
    do @(posedge clk); while (in_stall);
    while (!calm && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic tick();
    drive_item(OP_TICK, SLOT_W'($urandom), TIME_W'($urandom), 1'($urandom));
  endtask

  initial begin
    int r;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = OP_TICK;
    in_timer_slot = '0;
    in_timeout_ms = '0;
    in_periodic   = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: range edges, rejects, re-arm, periodic, several on one tick
    drive_item(OP_ARM, 6'd0,  27'd1, 1'b0);
    drive_item(OP_ARM, 6'd63, 27'd2, 1'b1);
    drive_item(OP_ARM, 6'd5,  27'd0, 1'b1);
    drive_item(OP_ARM, 6'd6,  TIMEOUT_CEIL, 1'b0);
    drive_item(OP_ARM, 6'd7,  TIMEOUT_CEIL + 27'd1, 1'b0);
    drive_item(OP_ARM, 6'd8,  27'h7FFFFFF, 1'b1);
    drive_item(OP_ARM, 6'd1,  27'd3, 1'b0);
    drive_item(OP_ARM, 6'd2,  27'd3, 1'b1);
    tick();
    tick();
    drive_item(OP_ARM, 6'd63, 27'd3, 1'b0);   // replaces the periodic one
    tick();
    tick();
    tick();
    tick();
    tick();
    drive_item(OP_ARM, 6'd6, 27'd1, 1'b0);
    tick();
    tick();

    // random: mostly short timeouts so timers expire, some wide and bad ones
    for (int n = 0; n < 300; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45)
        tick();
      else if (r < 88)
        drive_item(OP_ARM, SLOT_W'($urandom), TIME_W'($urandom_range(1, 12)),
                   1'($urandom_range(0, 3) == 0));
      else if (r < 95)
        drive_item(OP_ARM, SLOT_W'($urandom), TIME_W'($urandom), 1'($urandom));
      else
        drive_item(OP_ARM, SLOT_W'($urandom),
                   ($urandom_range(0, 1) != 0) ? TIMEOUT_CEIL + 27'd1 : '0,
                   1'($urandom));
    end
    in_valid <= 1'b0;

    // drain, then let the scan settle
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
